// ----- sv/lrg_pkg.sv -----
// Shared types, widths, codes and helper functions of the linear ramp generator.
// No dependencies; compiled first.

package lrg_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int TIME_BITS     = 24;
  localparam int GRAIN_BITS    = 16;
  localparam int DEFAULT_GRAIN = 20;

  // countdown must hold the default grain even for narrow grain registers
  localparam int DLY_W    = (GRAIN_BITS > 5) ? GRAIN_BITS : 5;
  localparam int MAG_W    = VALUE_BITS + 1;
  localparam int PROD_W   = MAG_W + TIME_BITS;
  localparam int ADD_W    = ((VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS) + 2;
  localparam int STEP_MAX = (MAG_W > TIME_BITS) ? MAG_W : TIME_BITS;
  localparam int STEP_W   = $clog2(STEP_MAX);
  localparam int CMP_W    = (DLY_W > TIME_BITS) ? DLY_W : TIME_BITS;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [TIME_BITS-1:0]         time_t;
  typedef logic [GRAIN_BITS-1:0]        grain_t;
  typedef logic [DLY_W-1:0]             dly_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic [ADD_W-1:0]             add_t;
  typedef logic [STEP_W-1:0]            step_t;
  typedef logic [CMP_W-1:0]             cmp_t;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_GO   = 2'd1,
    ACT_STOP = 2'd2,
    ACT_SET  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_CALC,
    S_EMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_DIFF,
    U_ABS,
    U_MUL,
    U_DIV,
    U_SUM
  } unit_state_t;

  function automatic dly_t eff_grain(input dly_t g);
    eff_grain = (g == '0) ? dly_t'(DEFAULT_GRAIN) : g;
  endfunction

  // min(grain, remaining); the result fits the countdown either way
  function automatic dly_t min_delay(input dly_t g, input time_t rem);
    cmp_t gw;
    cmp_t rw;
    gw = cmp_t'(g);
    rw = cmp_t'(rem);
    min_delay = (gw < rw) ? g : dly_t'(rw);
  endfunction

endpackage

// ----- sv/lrg_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
// Depends on lrg_pkg.

interface lrg_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  lrg_pkg::value_t       new_value;
  lrg_pkg::time_t        ramp_ticks;

  modport source (output valid, output action, output new_value, output ramp_ticks,
                  input ready);
  modport sink   (input valid, input action, input new_value, input ramp_ticks,
                  output ready);
endinterface

interface lrg_out_if;
  logic                  valid;
  logic                  ready;
  lrg_pkg::value_t       value;
  logic                  at_target;

  modport source (output valid, output value, output at_target, input ready);
  modport sink   (input valid, input value, input at_target, output ready);
endinterface

// ----- sv/lrg_interp.sv -----
// Iterative interpolator: start + sign(d) * floor(|d| * e / L) on one shared adder.
// Depends on lrg_pkg.

module lrg_interp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  lrg_pkg::value_t start_value,
  input  lrg_pkg::value_t target_value,
  input  lrg_pkg::time_t  elapsed,
  input  lrg_pkg::time_t  length,
  output logic            done,
  output lrg_pkg::value_t result
);

  lrg_pkg::unit_state_t state_r, state_nxt;
  lrg_pkg::step_t       step_r, step_nxt;
  logic                 neg_r, neg_nxt;
  lrg_pkg::mag_t        mag_r, mag_nxt;
  lrg_pkg::prod_t       prod_r, prod_nxt;
  lrg_pkg::time_t       rem_r, rem_nxt;
  lrg_pkg::value_t      result_r, result_nxt;
  logic                 done_r, done_nxt;

  // shared adder / subtractor
  lrg_pkg::add_t              add_a, add_b;
  logic                       add_sub;
  logic [lrg_pkg::ADD_W:0]    add_sum;
  logic                       add_carry;
  logic [lrg_pkg::TIME_BITS:0] div_t;

  assign div_t     = {rem_r, prod_r[lrg_pkg::MAG_W-1]};
  assign add_sum   = {1'b0, add_a} + {1'b0, add_b ^ {lrg_pkg::ADD_W{add_sub}}}
                   + (lrg_pkg::ADD_W+1)'(add_sub);
  assign add_carry = add_sum[lrg_pkg::ADD_W];

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      lrg_pkg::U_DIFF: begin
        add_a   = lrg_pkg::add_t'(target_value);
        add_b   = lrg_pkg::add_t'(start_value);
        add_sub = 1'b1;
      end
      lrg_pkg::U_ABS: begin
        add_b   = lrg_pkg::add_t'(mag_r);
        add_sub = neg_r;
      end
      lrg_pkg::U_MUL: begin
        add_a = lrg_pkg::add_t'(prod_r[lrg_pkg::PROD_W-1:lrg_pkg::TIME_BITS]);
        add_b = prod_r[0] ? lrg_pkg::add_t'(mag_r) : '0;
      end
      lrg_pkg::U_DIV: begin
        add_a   = lrg_pkg::add_t'(div_t);
        add_b   = lrg_pkg::add_t'(length);
        add_sub = 1'b1;
      end
      lrg_pkg::U_SUM: begin
        add_a   = lrg_pkg::add_t'(start_value);
        add_b   = lrg_pkg::add_t'(prod_r[lrg_pkg::MAG_W-1:0]);
        add_sub = neg_r;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrg_pkg::U_IDLE: if (start) state_nxt = lrg_pkg::U_DIFF;
      lrg_pkg::U_DIFF: state_nxt = lrg_pkg::U_ABS;
      lrg_pkg::U_ABS:  state_nxt = lrg_pkg::U_MUL;
      lrg_pkg::U_MUL: begin
        if (step_r == lrg_pkg::step_t'(lrg_pkg::TIME_BITS-1)) state_nxt = lrg_pkg::U_DIV;
      end
      lrg_pkg::U_DIV: begin
        if (step_r == lrg_pkg::step_t'(lrg_pkg::MAG_W-1)) state_nxt = lrg_pkg::U_SUM;
      end
      lrg_pkg::U_SUM:  state_nxt = lrg_pkg::U_IDLE;
      default:         state_nxt = lrg_pkg::U_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    step_nxt   = step_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    result_nxt = result_r;
    done_nxt   = 1'b0;
    unique case (state_r)
      lrg_pkg::U_IDLE: begin
      end
      lrg_pkg::U_DIFF: begin
        // signed difference fits MAG_W bits; top bit is its sign
        mag_nxt = add_sum[lrg_pkg::MAG_W-1:0];
        neg_nxt = add_sum[lrg_pkg::MAG_W-1];
      end
      lrg_pkg::U_ABS: begin
        mag_nxt  = add_sum[lrg_pkg::MAG_W-1:0];
        prod_nxt = {{lrg_pkg::MAG_W{1'b0}}, elapsed};
        step_nxt = '0;
      end
      lrg_pkg::U_MUL: begin
        // LSB-first shift-add: |d| * e
        prod_nxt = {add_sum[lrg_pkg::MAG_W:0], prod_r[lrg_pkg::TIME_BITS-1:1]};
        if (step_r == lrg_pkg::step_t'(lrg_pkg::TIME_BITS-1)) begin
          // product < 2^MAG_W * L, so the top part is already a valid remainder
          rem_nxt  = prod_nxt[lrg_pkg::PROD_W-1:lrg_pkg::MAG_W];
          step_nxt = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      lrg_pkg::U_DIV: begin
        // restoring divide, one quotient bit per cycle into the low bits
        rem_nxt = add_carry ? add_sum[lrg_pkg::TIME_BITS-1:0]
                            : div_t[lrg_pkg::TIME_BITS-1:0];
        prod_nxt[lrg_pkg::MAG_W-1:0] = {prod_r[lrg_pkg::MAG_W-2:0], add_carry};
        step_nxt = step_r + 1'b1;
      end
      lrg_pkg::U_SUM: begin
        result_nxt = add_sum[lrg_pkg::VALUE_BITS-1:0];
        done_nxt   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrg_pkg::U_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    result_r <= result_nxt;
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

// ----- sv/linear_ramp_generator_unit.sv -----
// Top level of the linear ramp generator: item sequencer, ramp state and output register.
// Depends on lrg_pkg, lrg_in_if / lrg_out_if and lrg_interp.

// Ramps a signed Q16.16 value to a target over a number of tick items, sending
// the interpolated value every grain ticks and the exact target at the end.
// Items are handled one at a time. A tick that sends nothing passes from the
// transfer through the evaluate state back to ready. An item that sends the
// target or a jump value goes on to the emit state, which loads the output
// register when it is free. An item that needs the interpolated value (a due
// tick inside the ramp, a go with a non-zero length before the last segment
// has run its length) first waits in the calculate state for the interpolator,
// whose single adder does a 24-step shift-add multiply and a 33-step restoring
// divide. A finished result sits in the output register, so the next item is
// taken while the result waits to be transferred. No clearing pass after reset.

module linear_ramp_generator_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  lrg_pkg::grain_t         cfg_wr_data,
  lrg_in_if.sink                  in_ch,
  lrg_out_if.source               out_ch
);

  lrg_pkg::ctrl_state_t state_r, state_nxt;

  // grain register; zero reads as the default grain
  lrg_pkg::dly_t   grain_r;
  lrg_pkg::dly_t   grain_eff;

  // ramp state
  lrg_pkg::value_t start_r, start_nxt;
  lrg_pkg::value_t target_r, target_nxt;
  lrg_pkg::time_t  rlen_r, rlen_nxt;
  lrg_pkg::time_t  elapsed_r, elapsed_nxt;
  lrg_pkg::dly_t   cnt_r, cnt_nxt;
  logic            ramping_r, ramping_nxt;

  // item held for the duration of its work
  lrg_pkg::action_t act_r;
  lrg_pkg::value_t  nv_r;
  lrg_pkg::time_t   len_r;

  // pending result
  lrg_pkg::value_t res_val_r, res_val_nxt;
  logic            res_at_r, res_at_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  lrg_pkg::value_t out_value_r, out_value_nxt;
  logic            out_at_r, out_at_nxt;

  logic            in_xfer;
  logic            ended;
  logic            emit_load;
  logic            apply_go;
  lrg_pkg::value_t go_iv;
  logic            unit_start;
  logic            unit_done;
  lrg_pkg::value_t unit_result;

  assign in_ch.ready = (state_r == lrg_pkg::S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign grain_eff   = lrg_pkg::eff_grain(grain_r);
  assign ended       = (elapsed_r >= rlen_r);
  assign emit_load   = (state_r == lrg_pkg::S_EMIT) && (!out_valid_r || out_ch.ready);

  // go restart: new segment starts at the value interpolated right now
  assign go_iv    = (state_r == lrg_pkg::S_CALC) ? unit_result : target_r;
  assign apply_go = (act_r == lrg_pkg::ACT_GO) && (len_r != '0) &&
                    (((state_r == lrg_pkg::S_EVAL) && ended) ||
                     ((state_r == lrg_pkg::S_CALC) && unit_done));

  assign unit_start = (state_r == lrg_pkg::S_EVAL) && (state_nxt == lrg_pkg::S_CALC);

  lrg_interp u_interp (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (unit_start),
    .start_value  (start_r),
    .target_value (target_r),
    .elapsed      (elapsed_r),
    .length       (rlen_r),
    .done         (unit_done),
    .result       (unit_result)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrg_pkg::S_IDLE: if (in_xfer) state_nxt = lrg_pkg::S_EVAL;
      lrg_pkg::S_EVAL: begin
        unique case (act_r) inside
          lrg_pkg::ACT_TICK: begin
            if (!ramping_r || (cnt_r > lrg_pkg::dly_t'(1))) state_nxt = lrg_pkg::S_IDLE;
            else if (ended)                               state_nxt = lrg_pkg::S_EMIT;
            else                                          state_nxt = lrg_pkg::S_CALC;
          end
          lrg_pkg::ACT_GO: begin
            if ((len_r == '0) || ended) state_nxt = lrg_pkg::S_EMIT;
            else                        state_nxt = lrg_pkg::S_CALC;
          end
          lrg_pkg::ACT_STOP, lrg_pkg::ACT_SET: state_nxt = lrg_pkg::S_IDLE;
          default:                             state_nxt = lrg_pkg::S_IDLE;
        endcase
      end
      lrg_pkg::S_CALC: if (unit_done) state_nxt = lrg_pkg::S_EMIT;
      lrg_pkg::S_EMIT: if (emit_load) state_nxt = lrg_pkg::S_IDLE;
      default:         state_nxt = lrg_pkg::S_IDLE;
    endcase
  end

  // ramp state and result updates
  always_comb begin
    start_nxt   = start_r;
    target_nxt  = target_r;
    rlen_nxt    = rlen_r;
    elapsed_nxt = elapsed_r;
    cnt_nxt     = cnt_r;
    ramping_nxt = ramping_r;
    res_val_nxt = res_val_r;
    res_at_nxt  = res_at_r;

    // time advances at the transfer of a tick, saturating
    if (in_xfer && (lrg_pkg::action_t'(in_ch.action) == lrg_pkg::ACT_TICK) &&
        (elapsed_r != '1)) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end

    if (state_r == lrg_pkg::S_EVAL) begin
      case (act_r) inside
        lrg_pkg::ACT_TICK: begin
          if (ramping_r) begin
            if (cnt_r > lrg_pkg::dly_t'(1)) begin
              cnt_nxt = cnt_r - 1'b1;
            end else if (ended) begin
              ramping_nxt = 1'b0;
              cnt_nxt     = '0;
              res_val_nxt = target_r;
              res_at_nxt  = 1'b1;
            end else begin
              cnt_nxt    = lrg_pkg::min_delay(grain_eff, rlen_r - elapsed_r);
              res_at_nxt = 1'b0;
            end
          end
        end
        lrg_pkg::ACT_GO: begin
          if (len_r == '0) begin
            // jump and report it as the target
            start_nxt   = nv_r;
            target_nxt  = nv_r;
            ramping_nxt = 1'b0;
            cnt_nxt     = '0;
            res_val_nxt = nv_r;
            res_at_nxt  = 1'b1;
          end
        end
        lrg_pkg::ACT_STOP: begin
          target_nxt  = start_r;
          ramping_nxt = 1'b0;
          cnt_nxt     = '0;
        end
        lrg_pkg::ACT_SET: begin
          start_nxt   = nv_r;
          target_nxt  = nv_r;
          ramping_nxt = 1'b0;
          cnt_nxt     = '0;
        end
        default: begin
        end
      endcase
    end

    if ((state_r == lrg_pkg::S_CALC) && unit_done && (act_r == lrg_pkg::ACT_TICK)) begin
      res_val_nxt = unit_result;
    end

    if (apply_go) begin
      start_nxt   = go_iv;
      target_nxt  = nv_r;
      rlen_nxt    = len_r;
      elapsed_nxt = '0;
      cnt_nxt     = lrg_pkg::min_delay(grain_eff, len_r);
      ramping_nxt = 1'b1;
      res_val_nxt = go_iv;
      res_at_nxt  = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_value_nxt = out_value_r;
    out_at_nxt    = out_at_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = res_val_r;
      out_at_nxt    = res_at_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrg_pkg::S_IDLE;
      grain_r     <= lrg_pkg::dly_t'(lrg_pkg::DEFAULT_GRAIN);
      start_r     <= '0;
      target_r    <= '0;
      rlen_r      <= '0;
      elapsed_r   <= '0;
      cnt_r       <= '0;
      ramping_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        grain_r <= lrg_pkg::dly_t'(cfg_wr_data);
      end
      start_r     <= start_nxt;
      target_r    <= target_nxt;
      rlen_r      <= rlen_nxt;
      elapsed_r   <= elapsed_nxt;
      cnt_r       <= cnt_nxt;
      ramping_r   <= ramping_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r <= lrg_pkg::action_t'(in_ch.action);
      nv_r  <= in_ch.new_value;
      len_r <= in_ch.ramp_ticks;
    end
    res_val_r   <= res_val_nxt;
    res_at_r    <= res_at_nxt;
    out_value_r <= out_value_nxt;
    out_at_r    <= out_at_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value     = out_value_r;
  assign out_ch.at_target = out_at_r;

endmodule

// ----- sv/lrg_checker.sv -----
// Port-level checks of the linear ramp generator, bound to the top level.
// Depends on lrg_pkg and linear_ramp_generator_unit.

module lrg_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic [1:0]      in_action,
  input logic            out_valid,
  input logic            out_ready,
  input lrg_pkg::value_t out_value,
  input logic            out_at_target
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // one item at a time: no transfer in the cycle after a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transfer");

  // stop and set items are silent
  a_silent_items: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid &&
     ((in_action == lrg_pkg::ACT_STOP) || (in_action == lrg_pkg::ACT_SET)))
    |=> !out_valid ##1 !out_valid)
    else $error("result after a stop or set item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_value) && $stable(out_at_target))
    else $error("stalled result changed");

endmodule

bind linear_ramp_generator_unit lrg_checker u_lrg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_action     (in_ch.action),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_value     (out_ch.value),
  .out_at_target (out_ch.at_target)
);
